@@ rtl/t3rdh_pkg.sv @@
package t3rdh_pkg;

  typedef enum logic [2:0] {
    KIND_PHOTON   = 3'd0,
    KIND_MARKER   = 3'd1,
    KIND_OVERFLOW = 3'd2,
    KIND_IGNORED  = 3'd3,
    KIND_READOUT  = 3'd4,
    KIND_DROPPED  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  localparam logic       CMD_READ    = 1'b1;
  localparam logic [5:0] OVF_CHANNEL = 6'h3F;
  localparam logic [5:0] MARKER_MAX  = 6'd15;
  localparam int         WRAP_SHIFT  = 10;   // overflow step of 1024 syncs
  localparam int         CH_W        = 6;
  localparam int         BIN_W       = 15;
  localparam int         NSYNC_W     = 10;
  localparam int         COUNT_W     = 32;
  localparam int         SYNC_W      = 64;
  // wide enough for 63 * 32768 + 32767
  localparam int         ADDR_WIDE_W = 23;

  typedef struct packed {
    logic               cmd;
    logic [31:0]        record;
    logic [CH_W-1:0]    read_channel;
    logic [BIN_W-1:0]   read_bin;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [SYNC_W-1:0]  sync_count;
    logic [CH_W-1:0]    channel_out;
    logic [BIN_W-1:0]   delay_bin;
    logic [3:0]         marker_bits;
    logic [COUNT_W-1:0] bin_count;
  } out_item_t;

  typedef struct packed {
    kind_t              kind;
    logic               in_range;
    logic               use_sync;
    logic [NSYNC_W-1:0] nsync;
    logic [CH_W-1:0]    channel_out;
    logic [BIN_W-1:0]   delay_bin;
    logic [3:0]         marker_bits;
  } dec_t;

endpackage

@@ rtl/t3rdh_ram.sv @@
module t3rdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/t3rdh_decode.sv @@
module t3rdh_decode
  import t3rdh_pkg::*;
#(
  parameter int NUM_CHANNELS = 8,
  parameter int HIST_BINS    = 32768,
  parameter int ADDR_W       = 18
) (
  input  in_item_t          item,
  output dec_t              dec,
  output logic [ADDR_W-1:0] addr
);

  logic [NSYNC_W-1:0]     nsync;
  logic [BIN_W-1:0]       dtime;
  logic [CH_W-1:0]        ch;
  logic                   special;
  logic [CH_W-1:0]        sel_ch;
  logic [BIN_W-1:0]       sel_bin;
  logic [ADDR_WIDE_W-1:0] addr_wide;
  logic                   in_range;

  assign nsync   = item.record[9:0];
  assign dtime   = item.record[24:10];
  assign ch      = item.record[30:25];
  assign special = item.record[31];

  assign sel_ch  = (item.cmd == CMD_READ) ? item.read_channel : ch;
  assign sel_bin = (item.cmd == CMD_READ) ? item.read_bin : dtime;

  assign in_range = ({1'b0, sel_ch} < 7'(NUM_CHANNELS)) &&
                    ({1'b0, sel_bin} < 16'(HIST_BINS));

  assign addr_wide = ADDR_WIDE_W'(sel_ch) * ADDR_WIDE_W'(HIST_BINS) +
                     ADDR_WIDE_W'(sel_bin);
  assign addr      = addr_wide[ADDR_W-1:0];

  always_comb begin
    dec             = '0;
    dec.kind        = KIND_IGNORED;
    dec.in_range    = in_range;
    dec.nsync       = nsync;
    if (item.cmd == CMD_READ) begin
      dec.kind        = KIND_READOUT;
      dec.channel_out = item.read_channel;
      dec.delay_bin   = item.read_bin;
    end else if (special) begin
      if (ch == OVF_CHANNEL) begin
        dec.kind = KIND_OVERFLOW;
      end else if (ch != '0 && ch <= MARKER_MAX) begin
        dec.kind        = KIND_MARKER;
        dec.use_sync    = 1'b1;
        dec.marker_bits = ch[3:0];
      end
    end else begin
      dec.kind        = in_range ? KIND_PHOTON : KIND_DROPPED;
      dec.use_sync    = 1'b1;
      dec.channel_out = ch;
      dec.delay_bin   = dtime;
    end
  end

endmodule

@@ rtl/t3_record_decode_histogram.sv @@
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid, in_stall | in_item  (cmd, record, read_channel, read_bin)
// out     | out | out_valid, out_stall | out_item (kind, sync_count, channel_out,
//         |     |                    |           delay_bin, marker_bits, bin_count)
//
// Each item is taken in ST_IDLE, which starts the histogram memory read, then the
// update and write back of that bin follow in ST_UPDATE. The registered read sets this.
// After reset the histogram is cleared one bin per cycle over all
// NUM_CHANNELS * HIST_BINS bins; in_stall stays high during that pass.
// A result waits in the output register; the next item is taken meanwhile and
// holds in its update cycle only while the output register is still full.
module t3_record_decode_histogram
  import t3rdh_pkg::*;
#(
  parameter int NUM_CHANNELS = 8,
  parameter int HIST_BINS    = 32768
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int DEPTH  = NUM_CHANNELS * HIST_BINS;
  localparam int ADDR_W = $clog2(DEPTH);

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [SYNC_W-1:0]  corr_r, corr_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r;
  dec_t               dec, dec_r;
  logic [ADDR_W-1:0]  addr, addr_r;

  logic               accept;
  logic               out_free;
  logic               clearing;
  logic               upd_fire;
  logic               clr_last;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] count;
  logic [SYNC_W-1:0]  sync;

  t3rdh_decode #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .HIST_BINS    (HIST_BINS),
    .ADDR_W       (ADDR_W)
  ) u_decode (
    .item (in_item),
    .dec  (dec),
    .addr (addr)
  );

  t3rdh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign clr_last = (clr_addr_r == ADDR_W'(DEPTH - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept) state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    clearing = 1'b0;
    upd_fire = 1'b0;
    case (state_r)
      ST_CLEAR:  clearing = 1'b1;
      ST_IDLE:   in_stall = 1'b0;
      ST_UPDATE: upd_fire = out_free;
      default:   in_stall = 1'b1;
    endcase
  end

  always_comb begin
    count = '0;
    if (dec_r.kind == KIND_PHOTON) begin
      count = ram_rdata + COUNT_W'(1);
    end else if (dec_r.kind == KIND_READOUT && dec_r.in_range) begin
      count = ram_rdata;
    end
  end

  assign sync = dec_r.use_sync ? corr_r + SYNC_W'(dec_r.nsync) : '0;

  assign ram_we    = clearing || (upd_fire && dec_r.kind == KIND_PHOTON);
  assign ram_waddr = clearing ? clr_addr_r : addr_r;
  assign ram_wdata = clearing ? '0 : count;

  assign clr_addr_nxt = clearing ? clr_addr_r + ADDR_W'(1) : clr_addr_r;

  always_comb begin
    corr_nxt = corr_r;
    if (upd_fire && dec_r.kind == KIND_OVERFLOW) begin
      corr_nxt = corr_r + {(SYNC_W - NSYNC_W - WRAP_SHIFT)'(0), dec_r.nsync,
                           WRAP_SHIFT'(0)};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (upd_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      corr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      corr_r      <= corr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      dec_r  <= dec;
      addr_r <= addr;
    end
    if (upd_fire) begin
      out_item_r.kind        <= dec_r.kind;
      out_item_r.sync_count  <= sync;
      out_item_r.channel_out <= dec_r.channel_out;
      out_item_r.delay_bin   <= dec_r.delay_bin;
      out_item_r.marker_bits <= dec_r.marker_bits;
      out_item_r.bin_count   <= count;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import t3rdh_pkg::*;

  localparam int NUM_CH   = 8;
  localparam int NUM_BINS = 32768;
  localparam logic CMD_RECORD = 1'b0;
  localparam int HOLD_CYCLES = 150;
  // clearing pass plus all traffic, taken several times over
  localparam longint TIMEOUT_NS = 64'd4_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  logic rx_stall = 1'b0;
  logic hold_stall = 1'b0;
  assign out_stall = rx_stall | hold_stall;

  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int hold_cycles_req = 0;

  // predictor state
  logic [63:0] sync_offset = '0;
  logic [31:0] bin_totals [int];
  out_item_t   expected_results [$];
  int          kind_total [8];
  int          results_checked = 0;
  int          mismatch_count = 0;

  t3_record_decode_histogram #(
    .NUM_CHANNELS(NUM_CH),
    .HIST_BINS   (NUM_BINS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t result %0d: %s", $realtime, results_checked, msg);
  endtask

  function automatic out_item_t decode_and_count(input in_item_t it);
    out_item_t   r;
    logic [9:0]  nsync;
    logic [14:0] dtime;
    logic [5:0]  ch;
    logic        special;
    int          idx;
    r = '0;
    r.kind = KIND_IGNORED;
    nsync = it.record[9:0];
    dtime = it.record[24:10];
    ch = it.record[30:25];
    special = it.record[31];
    if (it.cmd == CMD_READ) begin
      r.kind = KIND_READOUT;
      r.channel_out = it.read_channel;
      r.delay_bin = it.read_bin;
      idx = int'(it.read_channel) * NUM_BINS + int'(it.read_bin);
      if (it.read_channel < NUM_CH && it.read_bin < NUM_BINS && bin_totals.exists(idx))
        r.bin_count = bin_totals[idx];
    end else if (special) begin
      if (ch == OVF_CHANNEL) begin
        sync_offset = sync_offset + ({54'd0, nsync} << WRAP_SHIFT);
        r.kind = KIND_OVERFLOW;
      end else if (ch >= 6'd1 && ch <= MARKER_MAX) begin
        r.kind = KIND_MARKER;
        r.sync_count = sync_offset + {54'd0, nsync};
        r.marker_bits = ch[3:0];
      end
    end else begin
      r.sync_count = sync_offset + {54'd0, nsync};
      r.channel_out = ch;
      r.delay_bin = dtime;
      if (ch < NUM_CH && dtime < NUM_BINS) begin
        idx = int'(ch) * NUM_BINS + int'(dtime);
        if (!bin_totals.exists(idx)) bin_totals[idx] = '0;
        bin_totals[idx] = bin_totals[idx] + 32'd1;
        r.bin_count = bin_totals[idx];
        r.kind = KIND_PHOTON;
      end else begin
        r.kind = KIND_DROPPED;
      end
    end
    kind_total[r.kind]++;
    return r;
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(decode_and_count(item));
  endtask

  // drop valid so the last item is not taken again while waiting
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] make_record(input logic special, input logic [5:0] ch,
                                              input logic [14:0] dtime,
                                              input logic [9:0] nsync);
    return {special, ch, dtime, nsync};
  endfunction

  function automatic in_item_t record_item(input logic [31:0] rec);
    in_item_t it;
    it.cmd = CMD_RECORD;
    it.record = rec;
    it.read_channel = 6'($urandom);
    it.read_bin = 15'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(input logic [5:0] ch, input logic [14:0] bin);
    in_item_t it;
    it.cmd = CMD_READ;
    it.record = $urandom;
    it.read_channel = ch;
    it.read_bin = bin;
    return it;
  endfunction

  // concentrate on a few bins at both ends so counts climb
  function automatic logic [14:0] hot_dtime();
    case ($urandom_range(0, 2))
      0: return 15'($urandom_range(0, 3));
      1: return 15'($urandom_range(NUM_BINS - 4, NUM_BINS - 1));
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      return record_item(make_record(1'b0, 6'($urandom_range(0, NUM_CH + 1)), hot_dtime(),
                                     10'($urandom)));
    else if (pick < 58)
      return record_item(make_record(1'b0, 6'($urandom), 15'($urandom), 10'($urandom)));
    else if (pick < 66)
      return record_item(make_record(1'b1, OVF_CHANNEL, 15'($urandom), 10'($urandom)));
    else if (pick < 74)
      return record_item(make_record(1'b1, 6'($urandom_range(1, 15)), 15'($urandom),
                                     10'($urandom)));
    else if (pick < 79)
      return record_item($urandom);
    else if (pick < 94)
      return read_item(6'($urandom_range(0, NUM_CH + 1)), hot_dtime());
    else
      return read_item(6'($urandom), 15'($urandom));
  endfunction

  task automatic test_directed();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_item(read_item(6'd0, 15'd0));
    send_item(read_item(6'd63, 15'h7FFF));
    send_item(record_item(make_record(1'b0, 6'd0, 15'd0, 10'd0)));
    send_item(record_item(make_record(1'b0, 6'd7, 15'h7FFF, 10'h3FF)));
    send_item(record_item(make_record(1'b0, 6'd7, 15'h7FFF, 10'd5)));
    send_item(record_item(make_record(1'b0, 6'd8, 15'd3, 10'd1)));
    send_item(record_item(make_record(1'b0, 6'd63, 15'h7FFF, 10'h3FF)));
    send_item(record_item(make_record(1'b1, OVF_CHANNEL, 15'd0, 10'h3FF)));
    send_item(record_item(make_record(1'b1, OVF_CHANNEL, 15'h7FFF, 10'd0)));
    send_item(record_item(make_record(1'b0, 6'd0, 15'd0, 10'd2)));
    send_item(record_item(make_record(1'b1, 6'd1, 15'd0, 10'd0)));
    send_item(record_item(make_record(1'b1, MARKER_MAX, 15'h7FFF, 10'h3FF)));
    send_item(record_item(make_record(1'b1, 6'd0, 15'd9, 10'd9)));
    send_item(record_item(make_record(1'b1, 6'd16, 15'd9, 10'd9)));
    send_item(record_item(make_record(1'b1, 6'd62, 15'h7FFF, 10'h3FF)));
    send_item(read_item(6'd7, 15'h7FFF));
    send_item(read_item(6'd0, 15'd0));
    send_item(read_item(6'd8, 15'd3));
    send_item(read_item(6'(NUM_CH - 1), 15'd1));
    send_item(record_item(32'hFFFF_FFFF));
    send_item(record_item(32'h7FFF_FFFF));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n, input bit tx_gaps, input bit rx_gaps);
    tx_idle = tx_gaps;
    rx_idle = rx_gaps;
    repeat (n) send_item(random_item());
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    // receiver holds off while items keep coming, so in_stall must rise
    hold_cycles_req = HOLD_CYCLES;
    repeat (30)
      send_item(record_item(make_record(1'b0, 6'($urandom_range(0, 2)), 15'd1,
                                        10'($urandom))));
    wait_drained();
    send_item(read_item(6'd0, 15'd1));
    send_item(read_item(6'd1, 15'd1));
    wait_drained();
  endtask

  initial begin : result_side
    int wait_n;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_result(out_item);
        wait_n = rx_idle ? $urandom_range(0, 7) : 0;
        if (wait_n > 0) begin
          @(negedge clk);
          rx_stall <= 1'b1;
          repeat (wait_n) @(negedge clk);
          rx_stall <= 1'b0;
        end
      end
    end
  end

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with none expected, kind %0d", got.kind));
      return;
    end
    want = expected_results.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.sync_count !== want.sync_count)
      report_mismatch($sformatf("sync_count %0h, want %0h", got.sync_count,
                                want.sync_count));
    if (got.channel_out !== want.channel_out)
      report_mismatch($sformatf("channel_out %0d, want %0d", got.channel_out,
                                want.channel_out));
    if (got.delay_bin !== want.delay_bin)
      report_mismatch($sformatf("delay_bin %0d, want %0d", got.delay_bin, want.delay_bin));
    if (got.marker_bits !== want.marker_bits)
      report_mismatch($sformatf("marker_bits %0d, want %0d", got.marker_bits,
                                want.marker_bits));
    if (got.bin_count !== want.bin_count)
      report_mismatch($sformatf("bin_count %0d, want %0d", got.bin_count, want.bin_count));
    results_checked++;
  endtask

  initial begin : long_hold
    forever begin
      @(negedge clk);
      if (hold_cycles_req > 0) begin
        hold_stall <= 1'b1;
        repeat (hold_cycles_req) @(negedge clk);
        hold_stall <= 1'b0;
        hold_cycles_req = 0;
      end
    end
  end

  initial begin : run_limit
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("testbench failed");
    $finish;
  end

  initial begin : main
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(200, 1'b1, 1'b1);
    test_random_traffic(150, 1'b0, 1'b0);
    test_output_backpressure();
    test_random_traffic(150, 1'b1, 1'b0);
    test_random_traffic(150, 1'b0, 1'b1);
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    // catch any stray result after the last expected one
    repeat (20) @(posedge clk);
    $display("checked %0d results: %0d photons, %0d dropped, %0d readouts",
             results_checked, kind_total[KIND_PHOTON], kind_total[KIND_DROPPED],
             kind_total[KIND_READOUT]);
    $display("  %0d markers, %0d overflows, %0d ignored specials, %0d bins touched",
             kind_total[KIND_MARKER], kind_total[KIND_OVERFLOW], kind_total[KIND_IGNORED],
             bin_totals.num());
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/t3rdh_pkg.sv
rtl/t3rdh_ram.sv
rtl/t3rdh_decode.sv
rtl/t3_record_decode_histogram.sv
tb/sv/testbench.sv
